FILE: src/fot_pkg.sv
// ----------------------------------------------------------------------------
// fot_pkg
// Shared types, constants and the microcode program of the escape-time engine.
// ----------------------------------------------------------------------------
`default_nettype none

package fot_pkg;

  // Fixed-point format of z, c and the pixel coordinate
  localparam int FRAC_BITS   = 28;
  localparam int COUNT_WIDTH = 16;

  localparam int FIELD_W = 32;   // coordinate / constant field width
  localparam int VAL_W   = 60;   // internal signed value, holds +-2^58
  localparam int MAG_W   = 64;   // multiplier operand magnitude
  localparam int HALF_W  = MAG_W / 2;
  localparam int PROD_W  = 2 * MAG_W;

  localparam int LIMIT_W = 16;
  localparam int BAIL_W  = 32;
  localparam int CNT_OUT_W = 16;
  localparam int MAG_OUT_W = 36;

  // shifts that align |z|^2 (Q.F) with the Q8.24 threshold
  localparam int BAIL_SHL = (FRAC_BITS >= 24) ? FRAC_BITS - 24 : 0;
  localparam int MAG_SHL  = (FRAC_BITS < 24) ? 24 - FRAC_BITS : 0;

  localparam logic signed [63:0] SAT_LIM = 64'sh0400_0000_0000_0000;  // 2^58
  localparam logic [63:0]        MASK36  = 64'h0000_000F_FFFF_FFFF;

  typedef logic signed [VAL_W-1:0] val_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_MODE  = 3'd0,
    CFG_JC_RE = 3'd1,
    CFG_JC_IM = 3'd2,
    CFG_LIMIT = 3'd3,
    CFG_BAIL  = 3'd4
  } cfg_idx_e;

  // micro-operations
  typedef enum logic [2:0] {
    UOP_MUL,   // start a multiply, wait, write back
    UOP_MAG,   // |z|^2 = xx + yy
    UOP_TEST,  // jump to target when the pixel is finished
    UOP_POLY,  // s = x4 - 10 m + y4
    UOP_FACT,  // fre = s + 4 y4, fim = s + 4 x4
    UOP_NEXT,  // count++, jump to target
    UOP_EMIT   // hand the result to the output register
  } uop_e;

  typedef enum logic [2:0] {
    SRC_X, SRC_Y, SRC_XX, SRC_YY, SRC_FRE, SRC_FIM
  } src_e;

  typedef enum logic [2:0] {
    DST_XX, DST_YY, DST_X4, DST_Y4, DST_M, DST_X, DST_Y
  } dst_e;

  localparam int PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t PC_LOOP = 4'd0;
  localparam pc_t PC_EMIT = 4'd12;

  typedef struct packed {
    uop_e uop;
    src_e src_a;
    src_e src_b;
    dst_e dst;
    pc_t  target;
  } uword_t;

  // datapath strobes from the sequencer
  typedef struct packed {
    logic load;
    logic mag;
    logic poly;
    logic fact;
    logic incr;
    logic wb;
    dst_e dst;
    src_e src_a;
    src_e src_b;
  } dp_ctrl_t;

  function automatic uword_t mk_uw(uop_e u, src_e a, src_e b, dst_e d, pc_t t);
    uword_t w;
    w.uop    = u;
    w.src_a  = a;
    w.src_b  = b;
    w.dst    = d;
    w.target = t;
    return w;
  endfunction

  // control store
  function automatic uword_t ucode(pc_t pc);
    uword_t w;
    case (pc)
      4'd0:    w = mk_uw(UOP_MUL,  SRC_X,   SRC_X,   DST_XX, PC_LOOP);
      4'd1:    w = mk_uw(UOP_MUL,  SRC_Y,   SRC_Y,   DST_YY, PC_LOOP);
      4'd2:    w = mk_uw(UOP_MAG,  SRC_X,   SRC_X,   DST_XX, PC_LOOP);
      4'd3:    w = mk_uw(UOP_TEST, SRC_X,   SRC_X,   DST_XX, PC_EMIT);
      4'd4:    w = mk_uw(UOP_MUL,  SRC_XX,  SRC_XX,  DST_X4, PC_LOOP);
      4'd5:    w = mk_uw(UOP_MUL,  SRC_YY,  SRC_YY,  DST_Y4, PC_LOOP);
      4'd6:    w = mk_uw(UOP_MUL,  SRC_XX,  SRC_YY,  DST_M,  PC_LOOP);
      4'd7:    w = mk_uw(UOP_POLY, SRC_X,   SRC_X,   DST_XX, PC_LOOP);
      4'd8:    w = mk_uw(UOP_FACT, SRC_X,   SRC_X,   DST_XX, PC_LOOP);
      4'd9:    w = mk_uw(UOP_MUL,  SRC_X,   SRC_FRE, DST_X,  PC_LOOP);
      4'd10:   w = mk_uw(UOP_MUL,  SRC_Y,   SRC_FIM, DST_Y,  PC_LOOP);
      4'd11:   w = mk_uw(UOP_NEXT, SRC_X,   SRC_X,   DST_XX, PC_LOOP);
      4'd12:   w = mk_uw(UOP_EMIT, SRC_X,   SRC_X,   DST_XX, PC_LOOP);
      default: w = mk_uw(UOP_EMIT, SRC_X,   SRC_X,   DST_XX, PC_LOOP);
    endcase
    return w;
  endfunction

  typedef enum logic [1:0] {
    SEQ_IDLE, SEQ_EXEC, SEQ_MUL_WAIT
  } seq_state_e;

  typedef enum logic [1:0] {
    MUL_IDLE, MUL_RUN, MUL_FIN, MUL_DONE
  } mul_state_e;

endpackage

`default_nettype wire

FILE: src/fot_mul.sv
// ----------------------------------------------------------------------------
// fot_mul
// Iterative Q.F multiplier: four 32x32 partial products on one multiplier,
// magnitude truncated by FRAC_BITS, saturated to +-2^58.
// ----------------------------------------------------------------------------
`default_nettype none

module fot_mul import fot_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  val_t      a_i,
  input  val_t      b_i,
  output logic      done_o,
  output val_t      res_o
);

  mul_state_e state_q, state_d;
  logic [2:0] cnt_q, cnt_d;

  logic [MAG_W-1:0]  am_q, bm_q;
  logic              neg_q;
  logic [MAG_W-1:0]  pp_q;
  logic [1:0]        pj_q;
  logic [PROD_W-1:0] acc_q;
  val_t              res_q;

  logic signed [MAG_W-1:0] a_ext, b_ext;
  logic [MAG_W-1:0]        a_mag, b_mag;
  logic [1:0]              j;
  logic [HALF_W-1:0]       a_part, b_part;
  logic [PROD_W-1:0]       pp_sh;
  logic [PROD_W-1:0]       r_full;
  logic [VAL_W-1:0]        r_mag;

  always_comb begin
    a_ext = MAG_W'(a_i);
    b_ext = MAG_W'(b_i);
    a_mag = a_ext[MAG_W-1] ? MAG_W'(-a_ext) : MAG_W'(a_ext);
    b_mag = b_ext[MAG_W-1] ? MAG_W'(-b_ext) : MAG_W'(b_ext);

    j      = cnt_q[1:0];
    a_part = j[1] ? am_q[MAG_W-1:HALF_W] : am_q[HALF_W-1:0];
    b_part = j[0] ? bm_q[MAG_W-1:HALF_W] : bm_q[HALF_W-1:0];

    case (pj_q)
      2'd0:    pp_sh = PROD_W'(pp_q);
      2'd3:    pp_sh = PROD_W'(pp_q) << (2 * HALF_W);
      default: pp_sh = PROD_W'(pp_q) << HALF_W;
    endcase

    r_full = acc_q >> FRAC_BITS;
    if (r_full > PROD_W'(SAT_LIM)) begin
      r_mag = VAL_W'(SAT_LIM);
    end else begin
      r_mag = r_full[VAL_W-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_o  = 1'b0;
    case (state_q)
      MUL_IDLE: begin
        cnt_d = '0;
        if (start_i) begin
          state_d = MUL_RUN;
        end
      end
      MUL_RUN: begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd4) begin
          state_d = MUL_FIN;
        end
      end
      MUL_FIN: begin
        state_d = MUL_DONE;
      end
      MUL_DONE: begin
        done_o  = 1'b1;
        state_d = MUL_IDLE;
      end
      default: begin
        state_d = MUL_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MUL_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // partial product k is formed while product k-1 is accumulated
  always_ff @(posedge clk_i) begin
    if (state_q == MUL_IDLE && start_i) begin
      am_q  <= a_mag;
      bm_q  <= b_mag;
      neg_q <= a_i[VAL_W-1] ^ b_i[VAL_W-1];
      acc_q <= '0;
    end
    if (state_q == MUL_RUN) begin
      if (cnt_q != 3'd4) begin
        pp_q <= a_part * b_part;
        pj_q <= j;
      end
      if (cnt_q != 3'd0) begin
        acc_q <= acc_q + pp_sh;
      end
    end
    if (state_q == MUL_FIN) begin
      res_q <= neg_q ? -$signed(r_mag) : $signed(r_mag);
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

FILE: src/fot_seq.sv
// ----------------------------------------------------------------------------
// fot_seq
// Microcode sequencer: program counter, control store decode, jumps and
// the handshake with the multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module fot_seq import fot_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire logic exit_i,
  input  wire logic mul_done_i,
  input  wire logic emit_ready_i,
  output logic      mul_start_o,
  output logic      emit_o,
  output logic      busy_o,
  output dp_ctrl_t  ctrl_o
);

  seq_state_e state_q, state_d;
  pc_t        pc_q, pc_d;
  uword_t     uw;

  always_comb begin
    uw          = ucode(pc_q);
    state_d     = state_q;
    pc_d        = pc_q;
    mul_start_o = 1'b0;
    emit_o      = 1'b0;
    ctrl_o      = '0;
    ctrl_o.src_a = uw.src_a;
    ctrl_o.src_b = uw.src_b;
    ctrl_o.dst   = uw.dst;

    case (state_q)
      SEQ_IDLE: begin
        if (start_i) begin
          ctrl_o.load = 1'b1;
          pc_d        = PC_LOOP;
          state_d     = SEQ_EXEC;
        end
      end
      SEQ_EXEC: begin
        case (uw.uop)
          UOP_MUL: begin
            mul_start_o = 1'b1;
            state_d     = SEQ_MUL_WAIT;
          end
          UOP_MAG: begin
            ctrl_o.mag = 1'b1;
            pc_d       = pc_t'(pc_q + pc_t'(1));
          end
          UOP_TEST: begin
            pc_d = exit_i ? uw.target : pc_t'(pc_q + pc_t'(1));
          end
          UOP_POLY: begin
            ctrl_o.poly = 1'b1;
            pc_d        = pc_t'(pc_q + pc_t'(1));
          end
          UOP_FACT: begin
            ctrl_o.fact = 1'b1;
            pc_d        = pc_t'(pc_q + pc_t'(1));
          end
          UOP_NEXT: begin
            ctrl_o.incr = 1'b1;
            pc_d        = uw.target;
          end
          UOP_EMIT: begin
            if (emit_ready_i) begin
              emit_o  = 1'b1;
              state_d = SEQ_IDLE;
            end
          end
          default: begin
            state_d = SEQ_IDLE;
          end
        endcase
      end
      SEQ_MUL_WAIT: begin
        if (mul_done_i) begin
          ctrl_o.wb = 1'b1;
          pc_d      = pc_t'(pc_q + pc_t'(1));
          state_d   = SEQ_EXEC;
        end
      end
      default: begin
        state_d = SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
      pc_q    <= PC_LOOP;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
    end
  end

  assign busy_o = (state_q != SEQ_IDLE);

endmodule

`default_nettype wire

FILE: src/fot_dp.sv
// ----------------------------------------------------------------------------
// fot_dp
// Datapath of the escape-time engine: z, c, the power terms, the iteration
// counter and the escape test.
// ----------------------------------------------------------------------------
`default_nettype none

module fot_dp import fot_pkg::*; (
  input  wire logic                       clk_i,
  input  dp_ctrl_t                        ctrl_i,
  input  wire logic                       mode_i,
  input  wire logic signed [FIELD_W-1:0]  jc_re_i,
  input  wire logic signed [FIELD_W-1:0]  jc_im_i,
  input  wire logic [LIMIT_W-1:0]         limit_i,
  input  wire logic [BAIL_W-1:0]          bail_i,
  input  wire logic signed [FIELD_W-1:0]  point_re_i,
  input  wire logic signed [FIELD_W-1:0]  point_im_i,
  input  val_t                            mul_res_i,
  output val_t                            mul_a_o,
  output val_t                            mul_b_o,
  output logic                            exit_o,
  output logic [CNT_OUT_W-1:0]            count_o,
  output logic [MAG_OUT_W-1:0]            mag_o
);

  logic signed [FIELD_W-1:0] x_q, y_q, cre_q, cim_q;
  val_t                      xx_q, yy_q, x4_q, y4_q, m_q, s_q, fre_q, fim_q;
  logic [63:0]               mag_q;
  logic [COUNT_WIDTH-1:0]    count_q;

  logic signed [63:0] poly_sum, fre_sum, fim_sum, zc_sum;
  logic signed [FIELD_W-1:0] z_new;
  logic below;

  function automatic val_t sat58(logic signed [63:0] v);
    if (v > SAT_LIM) begin
      return VAL_W'(SAT_LIM);
    end else if (v < -SAT_LIM) begin
      return VAL_W'(-SAT_LIM);
    end
    return VAL_W'(v);
  endfunction

  function automatic logic signed [FIELD_W-1:0] clamp32(logic signed [63:0] v);
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      return 32'sh8000_0000;
    end
    return v[FIELD_W-1:0];
  endfunction

  function automatic val_t sel(src_e s, logic signed [FIELD_W-1:0] x,
                               logic signed [FIELD_W-1:0] y, val_t xx, val_t yy,
                               val_t fre, val_t fim);
    val_t r;
    case (s)
      SRC_X:   r = VAL_W'(x);
      SRC_Y:   r = VAL_W'(y);
      SRC_XX:  r = xx;
      SRC_YY:  r = yy;
      SRC_FRE: r = fre;
      SRC_FIM: r = fim;
      default: r = '0;
    endcase
    return r;
  endfunction

  // compare |z|^2 in Q.F with the Q8.24 threshold without losing bits
  function automatic logic below_bail(logic [63:0] mag, logic [BAIL_W-1:0] bail);
    logic r;
    if (FRAC_BITS >= 24) begin
      r = mag < (64'(bail) << BAIL_SHL);
    end else if (mag >= 64'h0000_0001_0000_0000) begin
      r = 1'b0;
    end else begin
      r = (mag << MAG_SHL) < 64'(bail);
    end
    return r;
  endfunction

  function automatic logic [MAG_OUT_W-1:0] to_q24(logic [63:0] mag);
    logic [63:0] m;
    if (FRAC_BITS >= 24) begin
      m = mag >> BAIL_SHL;
    end else if (mag > (MASK36 >> MAG_SHL)) begin
      m = MASK36;
    end else begin
      m = mag << MAG_SHL;
    end
    if (m > MASK36) begin
      m = MASK36;
    end
    return m[MAG_OUT_W-1:0];
  endfunction

  always_comb begin
    mul_a_o = sel(ctrl_i.src_a, x_q, y_q, xx_q, yy_q, fre_q, fim_q);
    mul_b_o = sel(ctrl_i.src_b, x_q, y_q, xx_q, yy_q, fre_q, fim_q);

    // 10 m as 8 m + 2 m
    poly_sum = 64'(x4_q) - ((64'(m_q) <<< 3) + (64'(m_q) <<< 1)) + 64'(y4_q);
    fre_sum  = 64'(s_q) + (64'(y4_q) <<< 2);
    fim_sum  = 64'(s_q) + (64'(x4_q) <<< 2);
    zc_sum   = 64'(mul_res_i) + ((ctrl_i.dst == DST_X) ? 64'(cre_q) : 64'(cim_q));
    z_new    = clamp32(zc_sum);

    below  = below_bail(mag_q, bail_i);
    // the counter saturating at all ones acts as the cap on the limit
    exit_o = (32'(count_q) >= 32'(limit_i)) || (&count_q) || !below;

    count_o = CNT_OUT_W'(count_q);
    mag_o   = to_q24(mag_q);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      count_q <= '0;
      if (mode_i) begin
        x_q   <= point_re_i;
        y_q   <= point_im_i;
        cre_q <= jc_re_i;
        cim_q <= jc_im_i;
      end else begin
        x_q   <= '0;
        y_q   <= '0;
        cre_q <= point_re_i;
        cim_q <= point_im_i;
      end
    end
    if (ctrl_i.wb) begin
      case (ctrl_i.dst)
        DST_XX:  xx_q <= mul_res_i;
        DST_YY:  yy_q <= mul_res_i;
        DST_X4:  x4_q <= mul_res_i;
        DST_Y4:  y4_q <= mul_res_i;
        DST_M:   m_q  <= mul_res_i;
        DST_X:   x_q  <= z_new;
        DST_Y:   y_q  <= z_new;
        default: m_q  <= mul_res_i;
      endcase
    end
    if (ctrl_i.mag) begin
      mag_q <= $unsigned(64'(xx_q) + 64'(yy_q));
    end
    if (ctrl_i.poly) begin
      s_q <= sat58(poly_sum);
    end
    if (ctrl_i.fact) begin
      fre_q <= sat58(fre_sum);
      fim_q <= sat58(fim_sum);
    end
    if (ctrl_i.incr) begin
      count_q <= count_q + COUNT_WIDTH'(1);
    end
  end

endmodule

`default_nettype wire

FILE: src/fifth_order_escape_time.sv
// ----------------------------------------------------------------------------
// fifth_order_escape_time
// Escape-time engine for z <- z^5 + c on signed Q4.28 coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one pixel coordinate.
//   Output channel (out_valid_o / out_stall_i) returns the iteration count
//   and the final |z|^2 in Q12.24, one result per pixel, in order.
//   Configuration writes (cfg_valid_i / cfg_ready_o, index + data) are
//   always taken; write only while no pixel is in flight.
// Operation:
//   All products go through one 32x32 multiplier, four partial products
//   per Q.F multiply. One pixel is worked on at a time; in_stall_o is
//   high while it runs.
// Reset: registers return to mode 0, Julia constant 0, limit 256,
//   bailout 4.0; the engine is idle and no result is pending.
// Output stall: the finished result waits in the output register; the next
//   pixel is taken meanwhile and the engine halts at its own result until
//   the register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module fifth_order_escape_time import fot_pkg::*; (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [2:0]                 cfg_index_i,
  input  wire logic [31:0]                cfg_data_i,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic signed [FIELD_W-1:0]  point_re_i,
  input  wire logic signed [FIELD_W-1:0]  point_im_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [CNT_OUT_W-1:0]            iteration_count_o,
  output logic [MAG_OUT_W-1:0]            final_mag_sq_o
);

  logic                      mode_q;
  logic signed [FIELD_W-1:0] jc_re_q, jc_im_q;
  logic [LIMIT_W-1:0]        limit_q;
  logic [BAIL_W-1:0]         bail_q;

  logic                  out_valid_q;
  logic [CNT_OUT_W-1:0]  count_q;
  logic [MAG_OUT_W-1:0]  mag_q;

  dp_ctrl_t             ctrl;
  logic                 start, exit_c, mul_start, mul_done, emit, emit_ready, busy;
  val_t                 mul_a, mul_b, mul_res;
  logic [CNT_OUT_W-1:0] dp_count;
  logic [MAG_OUT_W-1:0] dp_mag;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = busy;
  assign start       = in_valid_i && !busy;
  assign emit_ready  = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      jc_re_q <= '0;
      jc_im_q <= '0;
      limit_q <= 16'd256;
      bail_q  <= 32'h0400_0000;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_MODE:  mode_q  <= cfg_data_i[0];
        CFG_JC_RE: jc_re_q <= cfg_data_i;
        CFG_JC_IM: jc_im_q <= cfg_data_i;
        CFG_LIMIT: limit_q <= cfg_data_i[LIMIT_W-1:0];
        CFG_BAIL:  bail_q  <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      count_q <= dp_count;
      mag_q   <= dp_mag;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign iteration_count_o = count_q;
  assign final_mag_sq_o    = mag_q;

  fot_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .exit_i       (exit_c),
    .mul_done_i   (mul_done),
    .emit_ready_i (emit_ready),
    .mul_start_o  (mul_start),
    .emit_o       (emit),
    .busy_o       (busy),
    .ctrl_o       (ctrl)
  );

  fot_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  fot_dp u_dp (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .mode_i     (mode_q),
    .jc_re_i    (jc_re_q),
    .jc_im_i    (jc_im_q),
    .limit_i    (limit_q),
    .bail_i     (bail_q),
    .point_re_i (point_re_i),
    .point_im_i (point_im_i),
    .mul_res_i  (mul_res),
    .mul_a_o    (mul_a),
    .mul_b_o    (mul_b),
    .exit_o     (exit_c),
    .count_o    (dp_count),
    .mag_o      (dp_mag)
  );

endmodule

`default_nettype wire
